>>> hdl/hts_pkg.sv
package hts_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_TOGGLE = 2'd1,
		OP_REMOTE = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETPOINT        = 3'd0,
		REG_READY_MARGIN    = 3'd1,
		REG_DROP_BAND       = 3'd2,
		REG_AVG_COUNT       = 3'd3,
		REG_SHUTOFF_SECONDS = 3'd4
	} cfg_reg_t;

	localparam logic signed [11:0] SETPOINT_RST        = 12'sd1536;
	localparam logic        [7:0]  READY_MARGIN_RST    = 8'd8;
	localparam logic        [7:0]  DROP_BAND_RST       = 8'd32;
	localparam logic        [4:0]  AVG_COUNT_RST       = 5'd10;
	localparam logic        [15:0] SHUTOFF_SECONDS_RST = 16'd1800;

	typedef struct packed {
		op_t                op;
		logic               sensor_present;
		logic signed [11:0] temp_reading;
		logic               set_value;
	} in_item_t;

	typedef struct packed {
		logic               relay;
		logic               heater_enabled;
		logic               ready_res;
		logic               ready_rose;
		logic               temp_valid;
		logic signed [11:0] temp_report;
		logic               switch_report;
	} out_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] wdata;
	} cfg_write_t;

	typedef struct packed {
		logic signed [11:0] setpoint;
		logic        [7:0]  ready_margin;
		logic        [7:0]  drop_band;
		logic        [4:0]  avg_count;
		logic        [15:0] shutoff_seconds;
	} cfg_t;

endpackage

>>> hdl/hts_in_if.sv
interface hts_in_if;
	logic             valid;
	logic             ready;
	hts_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hdl/hts_out_if.sv
interface hts_out_if;
	logic              valid;
	logic              ready;
	hts_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hdl/hts_cfg_if.sv
interface hts_cfg_if;
	logic               valid;
	logic               ready;
	hts_pkg::cfg_write_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hdl/hts_cfg_regs.sv
module hts_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	hts_cfg_if.sink       cfg,
	output hts_pkg::cfg_t regs
);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.setpoint        <= hts_pkg::SETPOINT_RST;
			regs.ready_margin    <= hts_pkg::READY_MARGIN_RST;
			regs.drop_band       <= hts_pkg::DROP_BAND_RST;
			regs.avg_count       <= hts_pkg::AVG_COUNT_RST;
			regs.shutoff_seconds <= hts_pkg::SHUTOFF_SECONDS_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.data.index)
				hts_pkg::REG_SETPOINT:        regs.setpoint        <= cfg.data.wdata[11:0];
				hts_pkg::REG_READY_MARGIN:    regs.ready_margin    <= cfg.data.wdata[7:0];
				hts_pkg::REG_DROP_BAND:       regs.drop_band       <= cfg.data.wdata[7:0];
				hts_pkg::REG_AVG_COUNT:       regs.avg_count       <= cfg.data.wdata[4:0];
				hts_pkg::REG_SHUTOFF_SECONDS: regs.shutoff_seconds <= cfg.data.wdata;
				default: ;
			endcase
		end
	end

endmodule

>>> hdl/hts_ctrl.sv
module hts_ctrl #(
	parameter int MAX_WINDOW = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  hts_pkg::in_item_t  item,
	input  hts_pkg::cfg_t      cfg,
	output hts_pkg::out_item_t result
);

	localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W  = 12 + CNT_W;
	localparam int PROD_W = 14 + CNT_W;

	logic                     heater_q, heater_d;
	logic                     ready_q, ready_d;
	logic                     sensor_q, sensor_d;
	logic signed [11:0]       temp_q, temp_d;
	logic signed [SUM_W-1:0]  sum_q, sum_d;
	logic        [CNT_W-1:0]  fill_q, fill_d;
	logic                     relay_q, relay_d;
	logic                     armed_q, armed_d;
	logic        [15:0]       left_q, left_d;
	logic                     rose, sw;

	logic        [CNT_W-1:0]  win_n;
	logic signed [CNT_W:0]    win_s;
	logic signed [SUM_W-1:0]  sum_acc;
	logic        [CNT_W-1:0]  fill_inc;
	logic signed [12:0]       thr_base;
	logic signed [PROD_W-1:0] thr_prod;
	logic signed [PROD_W-1:0] sp_prod;
	logic signed [PROD_W-1:0] sum_ext;
	logic signed [PROD_W-1:0] dev;
	logic        [PROD_W-1:0] dev_abs;
	logic        [7+CNT_W:0]  band_u;
	logic        [PROD_W-1:0] band_ext;
	logic        [15:0]       left_dec;

	always_comb begin
		if (cfg.avg_count == 5'd0) begin
			win_n = CNT_W'(1);
		end else if (32'(cfg.avg_count) > MAX_WINDOW) begin
			win_n = CNT_W'(MAX_WINDOW);
		end else begin
			win_n = CNT_W'(cfg.avg_count);
		end
	end

	assign win_s    = {1'b0, win_n};
	assign sum_acc  = sum_q + {{(SUM_W-12){item.temp_reading[11]}}, item.temp_reading};
	assign fill_inc = fill_q + CNT_W'(1);
	assign thr_base = {cfg.setpoint[11], cfg.setpoint} - {5'd0, cfg.ready_margin};
	assign thr_prod = thr_base * win_s;
	assign sp_prod  = cfg.setpoint * win_s;
	assign sum_ext  = {{(PROD_W-SUM_W){sum_acc[SUM_W-1]}}, sum_acc};
	assign dev      = sum_ext - sp_prod;
	assign dev_abs  = dev[PROD_W-1] ? -dev : dev;
	assign band_u   = cfg.drop_band * win_n;
	assign band_ext = {{(PROD_W-8-CNT_W){1'b0}}, band_u};
	assign left_dec = (left_q != 16'd0) ? left_q - 16'd1 : left_q;

	always_comb begin
		heater_d = heater_q;
		ready_d  = ready_q;
		sensor_d = sensor_q;
		temp_d   = temp_q;
		sum_d    = sum_q;
		fill_d   = fill_q;
		relay_d  = relay_q;
		armed_d  = armed_q;
		left_d   = left_q;
		rose     = 1'b0;
		sw       = 1'b0;
		case (item.op)
			hts_pkg::OP_SAMPLE: begin
				// The shutoff countdown runs before the sample is used.
				if (armed_q) begin
					left_d = left_dec;
					if (left_dec == 16'd0) begin
						armed_d  = 1'b0;
						heater_d = 1'b0;
						ready_d  = 1'b0;
					end
				end
				if (item.sensor_present) begin
					sensor_d = 1'b1;
					temp_d   = item.temp_reading;
					if (heater_d) begin
						sum_d  = sum_acc;
						fill_d = fill_inc;
						if (fill_inc >= win_n) begin
							sum_d  = '0;
							fill_d = '0;
							if (!ready_d) begin
								if (sum_ext > thr_prod) begin
									ready_d = 1'b1;
									rose    = 1'b1;
									armed_d = 1'b1;
									left_d  = (cfg.shutoff_seconds != 16'd0) ?
										cfg.shutoff_seconds : 16'd1;
								end
							end else if (dev_abs > band_ext) begin
								ready_d = 1'b0;
							end
						end
					end
				end else begin
					sensor_d = 1'b0;
				end
				if (heater_d && sensor_d) begin
					relay_d = (temp_d < cfg.setpoint);
				end else if (!heater_d) begin
					relay_d = 1'b0;
				end
			end
			hts_pkg::OP_TOGGLE: begin
				heater_d = !heater_q;
				sw       = 1'b1;
			end
			hts_pkg::OP_REMOTE: begin
				heater_d = item.set_value;
				sw       = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heater_q <= 1'b0;
			ready_q  <= 1'b0;
			sensor_q <= 1'b0;
			temp_q   <= '0;
			sum_q    <= '0;
			fill_q   <= '0;
			relay_q  <= 1'b0;
			armed_q  <= 1'b0;
			left_q   <= '0;
		end else if (advance) begin
			heater_q <= heater_d;
			ready_q  <= ready_d;
			sensor_q <= sensor_d;
			temp_q   <= temp_d;
			sum_q    <= sum_d;
			fill_q   <= fill_d;
			relay_q  <= relay_d;
			armed_q  <= armed_d;
			left_q   <= left_d;
		end
	end

	assign result.relay          = relay_d;
	assign result.heater_enabled = heater_d;
	assign result.ready_res      = ready_d;
	assign result.ready_rose     = rose;
	assign result.temp_valid     = sensor_d;
	assign result.temp_report    = temp_d;
	assign result.switch_report  = sw;

endmodule

>>> hdl/heater_thermostat_ready_control.sv
// Flow: an item is captured in the input register, and its result is registered when the pipeline advances.
// Throughput: one item per cycle; the input register, the control update and
// the result register form a two-stage pipeline that stalls only when the result is not taken.
// Reset: arst_n clears all thermostat state and both valid flags at once, and loads the
// configuration registers with their default values; no clearing pass is needed.
module heater_thermostat_ready_control #(
	parameter int MAX_WINDOW = 16
) (
	input logic       clk,
	input logic       arst_n,
	hts_in_if.sink    item_in,
	hts_out_if.source result_out,
	hts_cfg_if.sink   cfg
);

	hts_pkg::cfg_t      regs;
	hts_pkg::in_item_t  item_s1;
	hts_pkg::out_item_t core_result;
	hts_pkg::out_item_t result_q;
	logic               valid_s1;
	logic               out_valid_q;
	logic               advance;

	hts_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	hts_ctrl #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (regs),
		.result  (core_result)
	);

	assign advance       = valid_s1 && (!out_valid_q || result_out.ready);
	assign item_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.ready) begin
			item_s1 <= item_in.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= core_result;
		end
	end

	assign result_out.valid = out_valid_q;
	assign result_out.data  = result_q;

	a_rose_sets_ready: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && result_out.data.ready_rose |-> result_out.data.ready_res)
		else $error("ready_rose without ready_res");

	a_rose_not_command: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid |-> !(result_out.data.ready_rose && result_out.data.switch_report))
		else $error("ready_rose on a command transfer");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && !result_out.ready |=> result_out.valid && $stable(result_out.data))
		else $error("result changed while waiting for transfer");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item_in.ready |-> valid_s1 && out_valid_q && !result_out.ready)
		else $error("input stalled with room in the pipeline");

endmodule
